[hdl/mbe_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time block with histogram.
// Used by mbe_mul, mbe_hist and mandelbrot_escape_histogram; depends on nothing.

package mbe_pkg;

  // Fixed-point format of c and z
  localparam int FRAC_BITS      = 28;
  localparam int ESCAPE_RADIUS  = 2;
  localparam int C_W            = 32;
  // z after one step can reach about +-8, so one extra bit over c
  localparam int Z_W            = C_W + 1;
  localparam int P_W            = 64;

  // Iteration limit and histogram geometry
  localparam int ITER_LIMIT_MAX = 1024;
  localparam int ITER_W         = 11;
  localparam int HIST_AW        = 10;
  localparam int CNT_W          = 32;

  localparam logic signed [C_W-1:0] C_LIM = C_W'(4) <<< FRAC_BITS;
  localparam logic [P_W-1:0] ESC_BOUND =
    P_W'(ESCAPE_RADIUS * ESCAPE_RADIUS) << (2 * FRAC_BITS);
  localparam logic [ITER_W-1:0] LIMIT_MAX = ITER_W'(ITER_LIMIT_MAX);

  // Operation codes
  localparam logic OP_ITERATE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [C_W-1:0]    c_real;
    logic signed [C_W-1:0]    c_imag;
    logic [HIST_AW-1:0]       bin_index;
  } in_item_t;

  typedef struct packed {
    logic [ITER_W-1:0]        iterations;
    logic                     escaped;
    logic [CNT_W-1:0]         bin_count;
    logic [CNT_W-1:0]         total_escaped;
  } out_item_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic                     en;
    logic                     clr;
    logic signed [Z_W-1:0]    a;
    logic signed [Z_W-1:0]    b;
  } mul_req_t;

  // Request to the histogram memory
  typedef struct packed {
    logic                     rd;
    logic                     wr;
    logic [HIST_AW-1:0]       addr;
    logic [CNT_W-1:0]         wdata;
  } hist_req_t;

  // Saturating increment of a counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    return r;
  endfunction

endpackage

[hdl/mandelbrot_escape_histogram.sv]
// Mandelbrot escape-time iterator with escape histogram (Q4.28); uses mbe_pkg/mul/hist.
// Iterate: each step runs STEP, SQR, SQI, CRS on one shared multiplier; the result
// is registered in DONE at the limit, or after HRD and HWR when the point escapes.
// Read: bin read in BRD, result registered in DONE. One transaction in flight at a time.
// Reset (rst_n, synchronous): limit 1024, total 0; the histogram is then cleared
// entry by entry, during which no input transaction is taken.

module mandelbrot_escape_histogram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mbe_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mbe_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mbe_pkg::ITER_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_SQR,
    ST_SQI,
    ST_CRS,
    ST_HRD,
    ST_HWR,
    ST_BRD,
    ST_DONE
  } state_t;

  state_t                             state_r;
  logic [mbe_pkg::ITER_W-1:0]         max_iter_r;
  logic [mbe_pkg::ITER_W-1:0]         lim_r;
  logic [mbe_pkg::ITER_W-1:0]         count_r;
  logic                               op_r;
  logic                               esc_r;
  logic [mbe_pkg::HIST_AW-1:0]        bin_r;
  logic signed [mbe_pkg::C_W-1:0]     cr_r;
  logic signed [mbe_pkg::C_W-1:0]     ci_r;
  logic signed [mbe_pkg::Z_W-1:0]     zr_r;
  logic signed [mbe_pkg::Z_W-1:0]     zi_r;
  logic signed [mbe_pkg::P_W-1:0]     prr_r;
  logic signed [mbe_pkg::P_W-1:0]     pii_r;
  logic [mbe_pkg::CNT_W-1:0]          total_r;
  logic                               out_valid_r;
  mbe_pkg::out_item_t                 out_data_r;

  logic                               accept;
  logic                               clearing;
  logic [mbe_pkg::CNT_W-1:0]          hist_rd;
  logic signed [mbe_pkg::P_W-1:0]     mul_p;
  mbe_pkg::mul_req_t                  mul_req;
  mbe_pkg::hist_req_t                 hist_req;
  logic signed [mbe_pkg::C_W-1:0]     cr_clamp;
  logic signed [mbe_pkg::C_W-1:0]     ci_clamp;
  logic [mbe_pkg::ITER_W-1:0]         lim_eff;
  logic signed [mbe_pkg::P_W-1:0]     re_sum;
  logic signed [mbe_pkg::P_W-1:0]     im_dbl;
  logic signed [mbe_pkg::P_W-1:0]     re_shift;
  logic signed [mbe_pkg::P_W-1:0]     im_shift;
  logic signed [mbe_pkg::Z_W-1:0]     zr_step;
  logic signed [mbe_pkg::Z_W-1:0]     zi_step;
  logic [mbe_pkg::P_W-1:0]            mag_sq;
  logic                               escape;
  logic [mbe_pkg::ITER_W-1:0]         count_inc;

  // Clamp one part of c to +-4
  function automatic logic signed [mbe_pkg::C_W-1:0] clamp_c(
    input logic signed [mbe_pkg::C_W-1:0] v
  );
    logic signed [mbe_pkg::C_W-1:0] r;
    if (v > mbe_pkg::C_LIM) begin
      r = mbe_pkg::C_LIM;
    end else if (v < -mbe_pkg::C_LIM) begin
      r = -mbe_pkg::C_LIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE) || clearing;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input conditioning: clamp c, bound the limit to 1..ITER_LIMIT_MAX
  always_comb begin
    cr_clamp = clamp_c(in_data.c_real);
    ci_clamp = clamp_c(in_data.c_imag);
    if (max_iter_r == '0) begin
      lim_eff = mbe_pkg::ITER_W'(1);
    end else if (max_iter_r > mbe_pkg::LIMIT_MAX) begin
      lim_eff = mbe_pkg::LIMIT_MAX;
    end else begin
      lim_eff = max_iter_r;
    end
  end

  // Next z from the stored products: (zr^2 - zi^2) >> F + cr, (2 zr zi) >> F + ci
  always_comb begin
    re_sum   = prr_r - pii_r;
    im_dbl   = mul_p <<< 1;
    re_shift = re_sum >>> mbe_pkg::FRAC_BITS;
    im_shift = im_dbl >>> mbe_pkg::FRAC_BITS;
    zr_step  = re_shift[mbe_pkg::Z_W-1:0] + {cr_r[mbe_pkg::C_W-1], cr_r};
    zi_step  = im_shift[mbe_pkg::Z_W-1:0] + {ci_r[mbe_pkg::C_W-1], ci_r};
  end

  // Escape test on the exact |z|^2; zi^2 is the product just registered
  always_comb begin
    mag_sq    = prr_r + mul_p;
    escape    = mag_sq > mbe_pkg::ESC_BOUND;
    count_inc = count_r + mbe_pkg::ITER_W'(1);
  end

  // Drive the shared multiplier: zr*zr, zi*zi, zr*zi in turn
  always_comb begin
    mul_req.en  = (state_r == ST_SQR) || (state_r == ST_SQI) || (state_r == ST_CRS);
    mul_req.clr = accept;
    mul_req.a   = (state_r == ST_SQI) ? zi_r : zr_r;
    mul_req.b   = (state_r == ST_SQR) ? zr_r : zi_r;
  end

  // Drive the histogram: read a bin and, for an escape, write its saturated increment
  always_comb begin
    hist_req.rd    = (state_r == ST_HRD) || (state_r == ST_BRD);
    hist_req.wr    = (state_r == ST_HWR);
    hist_req.addr  = (op_r == mbe_pkg::OP_READ) ? bin_r
                                                : count_r[mbe_pkg::HIST_AW-1:0];
    hist_req.wdata = mbe_pkg::sat_inc(hist_rd);
  end

  mbe_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_p)
  );

  mbe_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (hist_req),
    .rd_data  (hist_rd),
    .clearing (clearing)
  );

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_iter_r  <= mbe_pkg::LIMIT_MAX;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Configuration write
      if (cfg_valid && cfg_ready) begin
        max_iter_r <= cfg_data;
      end
      // Drop the result once the consumer takes it
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_data.op;
            bin_r   <= in_data.bin_index;
            cr_r    <= cr_clamp;
            ci_r    <= ci_clamp;
            lim_r   <= lim_eff;
            count_r <= '0;
            esc_r   <= 1'b0;
            prr_r   <= '0;
            pii_r   <= '0;
            state_r <= (in_data.op == mbe_pkg::OP_READ) ? ST_BRD : ST_STEP;
          end
        end
        ST_STEP: begin
          zr_r    <= zr_step;
          zi_r    <= zi_step;
          state_r <= ST_SQR;
        end
        ST_SQR: begin
          state_r <= ST_SQI;
        end
        ST_SQI: begin
          prr_r   <= mul_p;
          state_r <= ST_CRS;
        end
        ST_CRS: begin
          pii_r <= mul_p;
          if (escape) begin
            esc_r   <= 1'b1;
            state_r <= ST_HRD;
          end else begin
            count_r <= count_inc;
            state_r <= (count_inc == lim_r) ? ST_DONE : ST_STEP;
          end
        end
        ST_HRD: begin
          state_r <= ST_HWR;
        end
        ST_HWR: begin
          total_r <= mbe_pkg::sat_inc(total_r);
          state_r <= ST_DONE;
        end
        ST_BRD: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_data_r.iterations    <= count_r;
            out_data_r.escaped       <= esc_r;
            out_data_r.bin_count     <= (op_r == mbe_pkg::OP_READ) ? hist_rd : '0;
            out_data_r.total_escaped <= total_r;
            out_valid_r              <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // No point is in flight while the histogram sweep runs
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> state_r == ST_IDLE)
    else $error("histogram sweep overlaps a transaction");

  // A nonzero bin count only comes from a read, which reports no iterations
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bin_count != '0 |->
      out_data_r.iterations == '0 && !out_data_r.escaped)
    else $error("bin count on an iterate result");

  // An escaped result always carries a nonzero total
  a_esc_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.escaped |-> out_data_r.total_escaped != '0)
    else $error("escaped point not counted in total");

  // The running total never decreases
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> total_r >= $past(total_r))
    else $error("escape total decreased");
`endif

endmodule

[hdl/mbe_mul.sv]
// Shared signed multiplier with a registered product for the escape-time loop.
// Depends on mbe_pkg for the operand and product widths.

module mbe_mul (
  input  logic                          clk,
  input  mbe_pkg::mul_req_t             req,
  output logic signed [mbe_pkg::P_W-1:0] prod
);

  logic signed [mbe_pkg::Z_W-1:0]   a_s;
  logic signed [mbe_pkg::Z_W-1:0]   b_s;
  logic signed [2*mbe_pkg::Z_W-1:0] full;
  logic signed [mbe_pkg::P_W-1:0]   prod_r;

  // Form the full product; operands in use never exceed 2^31 in magnitude
  always_comb begin
    a_s  = req.a;
    b_s  = req.b;
    full = a_s * b_s;
  end

  // Hold the product until the next issue; clear at the start of a point
  always_ff @(posedge clk) begin
    if (req.clr) begin
      prod_r <= '0;
    end else if (req.en) begin
      prod_r <= full[mbe_pkg::P_W-1:0];
    end
  end

  assign prod = prod_r;

endmodule

[hdl/mbe_hist.sv]
// Escape histogram: a 1024 x 32 memory with a registered read port and a
// clearing sweep after reset. Depends on mbe_pkg for the request struct.

module mbe_hist (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbe_pkg::hist_req_t         req,
  output logic [mbe_pkg::CNT_W-1:0]  rd_data,
  output logic                       clearing
);

  localparam int DEPTH = 1 << mbe_pkg::HIST_AW;

  logic [mbe_pkg::CNT_W-1:0] mem [DEPTH];
  logic [mbe_pkg::HIST_AW:0] clr_cnt_r;
  logic [mbe_pkg::CNT_W-1:0] rd_data_r;

  // Sweep every entry once after reset; the top bit marks the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + (mbe_pkg::HIST_AW + 1)'(1);
    end
  end

  assign clearing = !clr_cnt_r[mbe_pkg::HIST_AW];

  // Write port: zero fill during the sweep, otherwise the requested write
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt_r[mbe_pkg::HIST_AW-1:0]] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Read port: data registered, held between reads
  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
